// ===== rtl/core/gar_pkg.sv =====
// gar_pkg: shared types, widths and constants of the gyro average/rotate/iir block
// used by gar_mac, gar_div and gyro_average_rotate_iir_top; no dependencies

package gar_pkg;

  localparam int IIR_ORDER_DEF    = 2;
  localparam int MAX_SAMPLES_DEF  = 255;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 24;
  localparam int COEF_W    = 24;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int ACC_W     = 64;
  // averaged magnitude before the count divide stays below 2^30
  localparam int QUO_W     = 30;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_GYRO  = 2'd0;
  localparam logic [1:0] OP_ACCEL = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FEED_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_2 = 3'd4;

  localparam logic signed [COEF_W-1:0] FEED_0_RESET   = 24'sd1048576;
  // 4096*pi/180 in q16: 1/16 deg/s to rad/s
  localparam logic signed [COEF_W-1:0] RAD_SCALE_Q16  = 24'sd4685083;
  // 0.7071 in q16
  localparam logic signed [COEF_W-1:0] HALF_SQRT2_Q16 = 24'sd46341;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_word_t;

  typedef struct packed {
    logic                     valid_res;
    logic signed [DATA_W-1:0] avg_x;
    logic signed [DATA_W-1:0] avg_y;
    logic signed [DATA_W-1:0] avg_z;
    logic signed [DATA_W-1:0] filt_x;
    logic signed [DATA_W-1:0] filt_y;
    logic signed [DATA_W-1:0] filt_z;
  } out_word_t;

  typedef struct packed {
    logic mul;
    logic clr;
    logic acc;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_MUL,
    S_AVG_PREP,
    S_AVG_DIV,
    S_ROT_MUL,
    S_ROT_RND,
    S_FLT_MUL,
    S_FLT_ACC,
    S_FLT_RND,
    S_EMIT
  } gar_state_e;

endpackage

// ===== rtl/core/gar_mac.sv =====
// gar_mac: shared signed multiplier with registered product and 64-bit accumulator
// depends on gar_pkg

module gar_mac import gar_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [COEF_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
    // accumulate takes the product registered in the previous cycle
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== rtl/core/gar_div.sv =====
// gar_div: restoring unsigned divider, one quotient bit per cycle
// depends on gar_pkg

module gar_div import gar_pkg::*; #(
  parameter int NUM_W = QUO_W,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top as quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/core/gyro_average_rotate_iir_top.sv =====
// gyro_average_rotate_iir_top: sample accumulation, averaging, 45 degree rotation and
// per-axis direct-form-I iir filter under one sequencer
// depends on gar_pkg, gar_mac, gar_div

// Gyro words add into saturating per-axis sums (at most MAX_SAMPLES of them), accel
// words set a seen flag; neither gives a result. A tick word gives one result. With
// a gyro or accel sample missing it is a zero result with valid_res low. Otherwise
// the three averages go through the serial divider one quotient bit per cycle, and
// the rotation and the filter terms go through the one shared 24x32 multiplier.
// in_stall_o is high from the tick until its result is loaded into the output
// register. A finished result waits in the output register; the next word is
// still taken.

module gyro_average_rotate_iir_top import gar_pkg::*; #(
  parameter int IIR_ORDER    = IIR_ORDER_DEF,
  parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  localparam int RING_LEN = IIR_ORDER + 1;
  localparam int SW       = $clog2(RING_LEN);
  localparam int NTERM    = 2 * IIR_ORDER + 1;
  localparam int TW       = $clog2(NTERM);
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);

  gar_state_e state_q, state_d;
  logic [1:0]    axis_q, axis_d;
  logic [TW-1:0] term_q, term_d;
  logic [SW-1:0] slot_q;
  logic          run_q;
  logic          accel_q;
  logic [CNT_W-1:0] count_q;
  logic signed [SUM_W-1:0]  sums_q [3];
  logic signed [COEF_W-1:0] feed0_q, feed1_q, feed2_q, back1_q, back2_q;
  logic signed [DATA_W-1:0] in_hist_q  [RING_LEN][3];
  logic signed [DATA_W-1:0] out_hist_q [RING_LEN][3];
  logic signed [DATA_W-1:0] avg_q  [3];
  logic signed [DATA_W-1:0] rot_q  [2];
  logic signed [DATA_W-1:0] filt_q [3];
  logic          avg_neg_q;
  logic          out_valid_q;
  out_word_t     out_q;

  logic          in_accept;
  logic          out_load;
  logic          div_start;
  logic          div_done;
  logic [QUO_W-1:0] div_quo;
  logic [QUO_W-1:0] div_num;
  mac_ctrl_t     mac_ctrl;
  logic signed [COEF_W-1:0] mac_a;
  logic signed [DATA_W-1:0] mac_b;
  logic signed [PROD_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]  mac_acc;

  logic signed [SAMPLE_W-1:0] samp [3];
  logic signed [SUM_W-1:0]    sum_next [3];
  logic signed [SUM_W:0]      sum_wide [3];
  logic          prod_neg;
  logic [PROD_W-1:0] prod_mag;
  logic [PROD_W-1:0] avg_pre;
  logic [PROD_W-1:0] rot_rnd;
  logic signed [DATA_W-1:0] quo_ext;
  logic signed [DATA_W-1:0] avg_val;
  logic signed [DATA_W-1:0] rot_val;
  logic signed [DATA_W-1:0] x_sel;
  logic          acc_neg;
  logic [ACC_W-1:0] acc_mag;
  logic [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_q20;
  logic signed [DATA_W-1:0] filt_val;
  logic [TW:0]   term_p1;
  logic [SW-1:0] tap_k;
  logic [SW:0]   past_sum;
  logic [SW-1:0] past;
  logic signed [COEF_W-1:0] feed_k, back_k;
  logic signed [DATA_W-1:0] sum_xy, dif_yx;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gar_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod),
    .acc_o  (mac_acc)
  );

  gar_div #(
    .NUM_W (QUO_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (count_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // saturating sample accumulation
  always_comb begin
    samp[0] = in_data_i.sample_x;
    samp[1] = in_data_i.sample_y;
    samp[2] = in_data_i.sample_z;
    for (int i = 0; i < 3; i++) begin
      sum_wide[i] = (SUM_W+1)'(sums_q[i]) + (SUM_W+1)'(samp[i]);
      if (sum_wide[i][SUM_W] != sum_wide[i][SUM_W-1]) begin
        sum_next[i] = sum_wide[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_next[i] = sum_wide[i][SUM_W-1:0];
      end
    end
  end

  // rounding of the registered product and accumulator, ties away from zero
  always_comb begin
    prod_neg = mac_prod[PROD_W-1];
    prod_mag = prod_neg ? PROD_W'(-mac_prod) : PROD_W'(mac_prod);
    // (|p| + count*2^15) >> 16, then divide by count
    avg_pre  = (prod_mag + (PROD_W'(count_q) << 15)) >> 16;
    div_num  = avg_pre[QUO_W-1:0];
    quo_ext  = DATA_W'(div_quo);
    avg_val  = avg_neg_q ? -quo_ext : quo_ext;
    rot_rnd  = (prod_mag + (PROD_W'(1) << 15)) >> 16;
    rot_val  = prod_neg ? -DATA_W'(rot_rnd) : DATA_W'(rot_rnd);

    acc_neg  = mac_acc[ACC_W-1];
    acc_mag  = acc_neg ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    acc_rnd  = (acc_mag + (ACC_W'(1) << 19)) >> 20;
    acc_q20  = acc_neg ? -$signed(acc_rnd) : $signed(acc_rnd);
    if (acc_q20[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){acc_q20[ACC_W-1]}}) begin
      filt_val = acc_q20[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      filt_val = acc_q20[DATA_W-1:0];
    end
  end

  // filter tap selection: term 0 is the new input, odd terms past inputs,
  // even terms past outputs
  always_comb begin
    term_p1  = {1'b0, term_q} + (TW+1)'(1);
    tap_k    = SW'(term_p1 >> 1);
    past_sum = {1'b0, slot_q} + (SW+1)'(RING_LEN) - {1'b0, tap_k};
    if (past_sum >= (SW+1)'(RING_LEN)) begin
      past = SW'(past_sum - (SW+1)'(RING_LEN));
    end else begin
      past = past_sum[SW-1:0];
    end
    feed_k = '0;
    back_k = '0;
    if (int'(tap_k) == 1) begin
      feed_k = feed1_q;
      back_k = back1_q;
    end else if (int'(tap_k) == 2) begin
      feed_k = feed2_q;
      back_k = back2_q;
    end
    x_sel  = (axis_q == 2'd2) ? avg_q[2] : rot_q[axis_q[0]];
    sum_xy = avg_q[0] + avg_q[1];
    dif_yx = avg_q[1] - avg_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    term_d    = term_q;
    mac_ctrl  = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept && in_data_i.opcode == OP_TICK) begin
          axis_d = 2'd0;
          term_d = '0;
          if (count_q == '0 || !accel_q) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_AVG_MUL;
          end
        end
      end
      S_AVG_MUL: begin
        mac_a        = RAD_SCALE_Q16;
        mac_b        = DATA_W'(sums_q[axis_q]);
        mac_ctrl.mul = 1'b1;
        state_d      = S_AVG_PREP;
      end
      S_AVG_PREP: begin
        div_start = 1'b1;
        state_d   = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (div_done) begin
          if (axis_q == 2'd2) begin
            axis_d  = 2'd0;
            state_d = S_ROT_MUL;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = S_AVG_MUL;
          end
        end
      end
      S_ROT_MUL: begin
        mac_a        = HALF_SQRT2_Q16;
        mac_b        = (axis_q == 2'd0) ? sum_xy : dif_yx;
        mac_ctrl.mul = 1'b1;
        state_d      = S_ROT_RND;
      end
      S_ROT_RND: begin
        if (axis_q == 2'd1) begin
          axis_d  = 2'd0;
          term_d  = '0;
          state_d = S_FLT_MUL;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_ROT_MUL;
        end
      end
      S_FLT_MUL: begin
        mac_ctrl.mul = 1'b1;
        mac_ctrl.clr = (term_q == '0);
        mac_ctrl.acc = (term_q != '0);
        if (term_q == '0) begin
          mac_a = feed0_q;
          mac_b = x_sel;
        end else if (term_q[0]) begin
          mac_a = feed_k;
          mac_b = in_hist_q[past][axis_q];
        end else begin
          mac_a = back_k;
          mac_b = out_hist_q[past][axis_q];
        end
        if (term_q == TW'(NTERM - 1)) begin
          state_d = S_FLT_ACC;
        end else begin
          term_d = term_q + TW'(1);
        end
      end
      S_FLT_ACC: begin
        mac_ctrl.acc = 1'b1;
        state_d      = S_FLT_RND;
      end
      S_FLT_RND: begin
        if (axis_q == 2'd2) begin
          state_d = S_EMIT;
        end else begin
          axis_d  = axis_q + 2'd1;
          term_d  = '0;
          state_d = S_FLT_MUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q      <= '0;
      term_q      <= '0;
      slot_q      <= '0;
      run_q       <= 1'b0;
      accel_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      feed0_q     <= FEED_0_RESET;
      feed1_q     <= '0;
      feed2_q     <= '0;
      back1_q     <= '0;
      back2_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        sums_q[i] <= '0;
      end
      for (int r = 0; r < RING_LEN; r++) begin
        for (int i = 0; i < 3; i++) begin
          in_hist_q[r][i]  <= '0;
          out_hist_q[r][i] <= '0;
        end
      end
    end else begin
      axis_q <= axis_d;
      term_q <= term_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FEED_0: feed0_q <= cfg_data_i;
          REG_FEED_1: feed1_q <= cfg_data_i;
          REG_FEED_2: feed2_q <= cfg_data_i;
          REG_BACK_1: back1_q <= cfg_data_i;
          REG_BACK_2: back2_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_accept) begin
        case (in_data_i.opcode)
          OP_GYRO: begin
            if (count_q != CNT_W'(MAX_SAMPLES)) begin
              for (int i = 0; i < 3; i++) begin
                sums_q[i] <= sum_next[i];
              end
              count_q <= count_q + CNT_W'(1);
            end
          end
          OP_ACCEL: accel_q <= 1'b1;
          OP_TICK:  run_q   <= (count_q != '0) && accel_q;
          default: ;
        endcase
      end

      if (state_q == S_FLT_RND) begin
        in_hist_q[slot_q][axis_q]  <= x_sel;
        out_hist_q[slot_q][axis_q] <= filt_val;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        if (run_q) begin
          for (int i = 0; i < 3; i++) begin
            sums_q[i] <= '0;
          end
          count_q <= '0;
          accel_q <= 1'b0;
          slot_q  <= (slot_q == SW'(RING_LEN - 1)) ? '0 : slot_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_AVG_PREP) begin
      avg_neg_q <= prod_neg;
    end
    if (state_q == S_AVG_DIV && div_done) begin
      avg_q[axis_q] <= avg_val;
    end
    if (state_q == S_ROT_RND) begin
      rot_q[axis_q[0]] <= rot_val;
    end
    if (state_q == S_FLT_RND) begin
      filt_q[axis_q] <= filt_val;
    end
    if (out_load) begin
      if (run_q) begin
        out_q.valid_res <= 1'b1;
        out_q.avg_x     <= rot_q[0];
        out_q.avg_y     <= rot_q[1];
        out_q.avg_z     <= avg_q[2];
        out_q.filt_x    <= filt_q[0];
        out_q.filt_y    <= filt_q[1];
        out_q.filt_z    <= filt_q[2];
      end else begin
        out_q <= '0;
      end
    end
  end

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.opcode == OP_TICK) |=> in_stall_o)
    else $error("tick word did not start the sequencer");

  a_sample_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.opcode == OP_GYRO && count_q == CNT_W'(MAX_SAMPLES))
    |=> $stable(count_q))
    else $error("gyro count moved past the cap");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |->
    (out_data_o.avg_x == '0 && out_data_o.avg_y == '0 && out_data_o.avg_z == '0 &&
     out_data_o.filt_x == '0 && out_data_o.filt_y == '0 && out_data_o.filt_z == '0))
    else $error("skipped tick carries nonzero fields");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_AVG_DIV)
    else $error("divider finished outside the averaging step");

endmodule

// ===== bench/tb_gyro_average_rotate_iir_top.sv =====
// tb_gyro_average_rotate_iir_top: self-checking bench for the gyro average/rotate/iir block
// drives gyro, accel and tick words, predicts every result and checks it field by field
// depends on gar_pkg and gyro_average_rotate_iir_top

module tb_gyro_average_rotate_iir_top;
  import gar_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 160;
  localparam int WATCHDOG_CYCLES = 400_000;
  localparam int PHASE_WORDS     = 60;
  localparam int RING            = IIR_ORDER_DEF + 1;

  localparam logic [1:0]        OP_UNUSED = 2'd3;
  localparam logic [15:0]       RATE_MAX  = 16'h7fff;
  localparam logic [15:0]       RATE_MIN  = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 24'h7fffff;
  localparam logic [COEF_W-1:0] COEF_MIN  = 24'h800000;

  localparam longint DEG16_TO_RAD_Q16 = 4685083;
  localparam longint HALF_ROOT2_Q16   = 46341;
  localparam longint SUM_HI           = 8388607;
  localparam longint SUM_LO           = -SUM_HI - 1;
  localparam longint OUT_HI           = 2147483647;
  localparam longint OUT_LO           = -OUT_HI - 1;

  // predicts the rate results and keeps the ones still to come
  class rate_filter_sb;
    logic signed [COEF_W-1:0] coef_ff[3];
    logic signed [COEF_W-1:0] coef_fb[3];
    logic signed [SUM_W-1:0]  sum_q[3];
    int unsigned              n_samples;
    bit                       accel_q;
    logic signed [31:0]       x_hist[RING][3];
    logic signed [31:0]       y_hist[RING][3];
    int                       slot;
    out_word_t                expected_q[$];
    int                       n_err;
    int                       n_results;
    int                       n_valid;

    function new();
      coef_ff[0] = FEED_0_RESET;
      coef_ff[1] = '0;
      coef_ff[2] = '0;
      coef_fb    = '{default: '0};
      sum_q      = '{default: '0};
      n_samples  = 0;
      accel_q    = 1'b0;
      x_hist     = '{default: '{default: '0}};
      y_hist     = '{default: '{default: '0}};
      slot       = 0;
      n_err      = 0;
      n_results  = 0;
      n_valid    = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        REG_FEED_0: coef_ff[0] = val;
        REG_FEED_1: coef_ff[1] = val;
        REG_FEED_2: coef_ff[2] = val;
        REG_BACK_1: coef_fb[1] = val;
        REG_BACK_2: coef_fb[2] = val;
        default: ;
      endcase
    endfunction

    function longint ff_coef(int k);
      if (k > 2) return 0;
      return coef_ff[k];
    endfunction

    function longint fb_coef(int k);
      if (k < 1 || k > 2) return 0;
      return coef_fb[k];
    endfunction

    // nearest, ties away from zero
    function longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function void note_input(in_word_t w);
      logic signed [15:0] smp[3];
      longint             avg[3];
      longint             rot[3];
      longint             acc;
      longint             s;
      logic signed [31:0] filt[3];
      int                 past;
      out_word_t          res;
      smp[0] = w.sample_x;
      smp[1] = w.sample_y;
      smp[2] = w.sample_z;
      case (w.opcode)
        OP_GYRO: begin
          if (n_samples < MAX_SAMPLES_DEF) begin
            for (int i = 0; i < 3; i++) begin
              s = longint'(sum_q[i]) + longint'(smp[i]);
              if (s > SUM_HI) s = SUM_HI;
              if (s < SUM_LO) s = SUM_LO;
              sum_q[i] = SUM_W'(s);
            end
            n_samples++;
          end
        end
        OP_ACCEL: accel_q = 1'b1;
        OP_TICK: begin
          res = '0;
          if (n_samples != 0 && accel_q) begin
            for (int i = 0; i < 3; i++) begin
              avg[i] = round_div(longint'(sum_q[i]) * DEG16_TO_RAD_Q16,
                                 longint'(n_samples) * 65536);
            end
            rot[0] = round_div((avg[0] + avg[1]) * HALF_ROOT2_Q16, 65536);
            rot[1] = round_div((avg[1] - avg[0]) * HALF_ROOT2_Q16, 65536);
            rot[2] = avg[2];
            for (int i = 0; i < 3; i++) begin
              x_hist[slot][i] = 32'(rot[i]);
              acc = ff_coef(0) * rot[i];
              for (int k = 1; k <= IIR_ORDER_DEF; k++) begin
                past = (slot + RING - k) % RING;
                acc += ff_coef(k) * longint'(x_hist[past][i]);
                acc += fb_coef(k) * longint'(y_hist[past][i]);
              end
              s = round_div(acc, longint'(1) << 20);
              if (s > OUT_HI) s = OUT_HI;
              if (s < OUT_LO) s = OUT_LO;
              filt[i] = 32'(s);
              y_hist[slot][i] = filt[i];
            end
            slot = (slot + 1) % RING;
            res.valid_res = 1'b1;
            res.avg_x     = 32'(rot[0]);
            res.avg_y     = 32'(rot[1]);
            res.avg_z     = 32'(rot[2]);
            res.filt_x    = filt[0];
            res.filt_y    = filt[1];
            res.filt_z    = filt[2];
            sum_q     = '{default: '0};
            n_samples = 0;
            accel_q   = 1'b0;
          end
          expected_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic signed [31:0] want, logic signed [31:0] got);
      n_err++;
      if (n_err <= 10) $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check(out_word_t got);
      out_word_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("[%0t] result word with no tick pending", $time);
        return;
      end
      want = expected_q.pop_front();
      if (want.valid_res) n_valid++;
      if (got.valid_res !== want.valid_res) flag("valid_res", want.valid_res, got.valid_res);
      if (got.avg_x !== want.avg_x)   flag("avg_x", want.avg_x, got.avg_x);
      if (got.avg_y !== want.avg_y)   flag("avg_y", want.avg_y, got.avg_y);
      if (got.avg_z !== want.avg_z)   flag("avg_z", want.avg_z, got.avg_z);
      if (got.filt_x !== want.filt_x) flag("filt_x", want.filt_x, got.filt_x);
      if (got.filt_y !== want.filt_y) flag("filt_y", want.filt_y, got.filt_y);
      if (got.filt_z !== want.filt_z) flag("filt_z", want.filt_z, got.filt_z);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COEF_W-1:0]    cfg_data_i;

  rate_filter_sb sb;
  int            n_items;
  int            gap_pct;
  int            stall_pct;

  gyro_average_rotate_iir_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
  end

  // receiver back-pressure in bursts
  initial begin : out_back_pressure
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        hold = $urandom_range(1, 8);
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return RATE_MAX;
      1: return RATE_MIN;
      2: return 16'(int'($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    in_word_t w;
    int       gap;
    w.opcode   = op;
    w.sample_x = x;
    w.sample_y = y;
    w.sample_z = z;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(w);
    if (op != OP_UNUSED) n_items++;
  endtask

  task automatic send_gyro();
    send_word(OP_GYRO, pick_rate(), pick_rate(), pick_rate());
  endtask

  task automatic send_other(input logic [1:0] op);
    send_word(op, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_coef(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // lower valid, let every tick come out, then give the sequencer time to go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] f0, input logic [COEF_W-1:0] f1,
                            input logic [COEF_W-1:0] f2, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2);
    write_reg(REG_FEED_0, f0);
    write_reg(REG_FEED_1, f1);
    // unmapped index, must not land anywhere
    write_reg(REG_BACK_2 + 3'd1 + 3'($urandom_range(0, 2)), 24'($urandom));
    write_reg(REG_FEED_2, f2);
    write_reg(REG_BACK_1, b1);
    write_reg(REG_BACK_2, b2);
  endtask

  function automatic logic [COEF_W-1:0] mild_coef();
    return 24'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  task automatic configure(input int setting);
    case (setting)
      1: load_coefs(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef());
      2: load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      3: load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      4: load_coefs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom));
      default: load_coefs(COEF_MAX, COEF_MIN, '0, COEF_MIN, COEF_MAX);
    endcase
  endtask

  task automatic run_directed();
    send_word(OP_TICK, '1, '1, '1);
    send_word(OP_GYRO, RATE_MAX, RATE_MAX, RATE_MAX);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_ACCEL, RATE_MIN, 16'h1234, RATE_MAX);
    send_word(OP_TICK, '1, '0, '1);
    send_word(OP_ACCEL, '0, '0, '0);
    send_word(OP_TICK, '0, '1, '0);
    send_word(OP_GYRO, RATE_MIN, RATE_MIN, RATE_MIN);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_GYRO, RATE_MAX, RATE_MIN, 16'h0001);
    send_word(OP_GYRO, 16'hffff, 16'h0000, RATE_MIN);
    send_word(OP_GYRO, 16'h0003, 16'hfffd, 16'h0000);
    send_word(OP_ACCEL, '1, '1, '1);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_GYRO, '0, '0, '0);
    send_word(OP_ACCEL, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_UNUSED, '0, '0, '0);
    send_word(OP_GYRO, 16'h0001, 16'hffff, 16'h0001);
    send_word(OP_ACCEL, '0, '0, '0);
    send_word(OP_TICK, '1, '1, '1);
  endtask

  // runs the sums into the sample cap with one sign per axis
  task automatic run_cap_fill();
    logic [15:0] ext[3];
    for (int i = 0; i < 3; i++) ext[i] = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
    send_other(OP_ACCEL);
    repeat (MAX_SAMPLES_DEF + 4) send_word(OP_GYRO, ext[0], ext[1], ext[2]);
    send_other(OP_TICK);
  endtask

  task automatic run_sequence();
    int kind;
    int n;
    int accel_at;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(1, 8);
    if (kind < 75) begin
      accel_at = $urandom_range(0, n);
      for (int i = 0; i <= n; i++) begin
        if (i == accel_at) send_other(OP_ACCEL);
        if (i < n) send_gyro();
        if ($urandom_range(0, 19) == 0) send_other(OP_UNUSED);
      end
      send_other(OP_TICK);
    end else if (kind < 85) begin
      repeat (n) send_gyro();
      send_other(OP_TICK);
    end else if (kind < 92) begin
      send_other(OP_ACCEL);
      send_other(OP_TICK);
    end else if (kind < 96) begin
      repeat (n) send_other(OP_UNUSED);
    end else begin
      send_other(OP_TICK);
    end
  endtask

  initial begin
    int target;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    n_items     = 0;
    gap_pct     = 20;
    stall_pct   = 20;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    for (int setting = 0; setting < 6; setting++) begin
      if (setting != 0) begin
        settle();
        configure(setting);
      end
      // last stretch runs with no idling on either side
      if (setting == 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (setting == 2) run_cap_fill();
      target = n_items + PHASE_WORDS;
      while (n_items < target) begin
        if (setting != 5) begin
          gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
          stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
        end
        run_sequence();
      end
    end
    settle();

    $display("sent %0d gyro/accel/tick words under six coefficient settings", n_items);
    $display("checked %0d results, %0d with the filter run, %0d mismatches",
             sb.n_results, sb.n_valid, sb.n_err);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gar_pkg.sv
rtl/core/gar_mac.sv
rtl/core/gar_div.sv
rtl/core/gyro_average_rotate_iir_top.sv
bench/tb_gyro_average_rotate_iir_top.sv
